>>> design/npg_pkg.sv
// Shared types, constants and saturation helpers for the nearest-prototype grid classifier.
package npg_pkg;

  localparam int Q_W         = 32;
  localparam int CLASS_W     = 8;
  localparam int ENTRY_IDX_W = 6;
  localparam int COORD_W     = 12;
  localparam int SCORE_W     = 48;
  localparam int PCOUNT_W    = 7;
  localparam int CFG_IDX_W   = 3;

  localparam logic KIND_LOAD     = 1'b0;
  localparam logic KIND_CLASSIFY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_PROTO_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_START     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_START     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP      = 3'd4;

  localparam logic signed [63:0] Q_MAX_64     = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] Q_MIN_64     = -64'sh0000_0000_8000_0000;
  localparam logic signed [63:0] SCORE_MAX_64 = 64'sh0000_7fff_ffff_ffff;
  localparam logic signed [63:0] SCORE_MIN_64 = -64'sh0000_8000_0000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // One prototype entry as it sits in the table memory.
  typedef struct packed {
    logic signed [Q_W-1:0] metric_a;
    logic signed [Q_W-1:0] metric_b;
    logic signed [Q_W-1:0] metric_d;
    logic signed [Q_W-1:0] centre_x;
    logic signed [Q_W-1:0] centre_y;
    logic signed [Q_W-1:0] offset;
    logic [CLASS_W-1:0]    cls;
  } entry_t;

  typedef struct packed {
    logic write;
    logic start;
    logic issue;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic issue_last;
    logic pipe_empty;
  } status_t;

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [63:0] v);
    logic signed [Q_W-1:0] r;
    if (v > Q_MAX_64) begin
      r = Q_MAX_64[Q_W-1:0];
    end else if (v < Q_MIN_64) begin
      r = Q_MIN_64[Q_W-1:0];
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SCORE_W-1:0] sat_score(input logic signed [63:0] v);
    logic signed [SCORE_W-1:0] r;
    if (v > SCORE_MAX_64) begin
      r = SCORE_MAX_64[SCORE_W-1:0];
    end else if (v < SCORE_MIN_64) begin
      r = SCORE_MIN_64[SCORE_W-1:0];
    end else begin
      r = v[SCORE_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> design/npg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module npg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/npg_ctrl.sv
// Controller state machine: input/output handshakes and sequencing of the table scan.
module npg_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_kind,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output npg_pkg::cmd_t    cmd,
  input  npg_pkg::status_t st
);
  import npg_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_stall      = 1'b1;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_kind == KIND_CLASSIFY) begin
            cmd.start = 1'b1;
            state_nxt = ST_SCAN;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (st.issue_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (st.pipe_empty) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // The result register may still hold the previous beat.
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

>>> design/npg_datapath.sv
// Datapath: configuration registers, prototype memory, scoring pipeline and best-entry tracking.
module npg_datapath #(
  parameter int MAX_ENTRIES = 64,
  parameter int GRID_BITS   = 12
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  npg_pkg::cmd_t                           cmd,
  output npg_pkg::status_t                        st,
  input  logic                                    cfg_we,
  input  logic [npg_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [npg_pkg::Q_W-1:0]                 cfg_data,
  input  logic [npg_pkg::ENTRY_IDX_W-1:0]         in_entry_index,
  input  logic signed [npg_pkg::Q_W-1:0]          in_metric_a,
  input  logic signed [npg_pkg::Q_W-1:0]          in_metric_b,
  input  logic signed [npg_pkg::Q_W-1:0]          in_metric_d,
  input  logic signed [npg_pkg::Q_W-1:0]          in_centre_x,
  input  logic signed [npg_pkg::Q_W-1:0]          in_centre_y,
  input  logic signed [npg_pkg::Q_W-1:0]          in_offset,
  input  logic [npg_pkg::CLASS_W-1:0]             in_class_in,
  input  logic [npg_pkg::COORD_W-1:0]             in_column,
  input  logic [npg_pkg::COORD_W-1:0]             in_grid_row,
  output logic [npg_pkg::CLASS_W-1:0]             out_class_out,
  output logic [npg_pkg::ENTRY_IDX_W-1:0]         out_best_entry
);
  import npg_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = (IDX_W + 1 > PCOUNT_W) ? IDX_W + 1 : PCOUNT_W;
  localparam int GB    = (GRID_BITS < COORD_W) ? GRID_BITS : COORD_W;
  localparam logic [COORD_W-1:0] GRID_MASK = COORD_W'((1 << GB) - 1);
  localparam logic [31:0]        MAX_U     = 32'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0]   MAX_CNT   = CNT_W'(MAX_ENTRIES);
  localparam logic [IDX_W-1:0]   LAST_MAX  = IDX_W'(MAX_ENTRIES - 1);
  localparam int                 ENTRY_W   = $bits(entry_t);

  // Configuration registers.
  logic [PCOUNT_W-1:0]   proto_count_r;
  logic signed [Q_W-1:0] x_start_r, y_start_r, x_step_r, y_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proto_count_r <= PCOUNT_W'(1);
      x_start_r     <= '0;
      y_start_r     <= '0;
      x_step_r      <= '0;
      y_step_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROTO_COUNT: proto_count_r <= cfg_data[PCOUNT_W-1:0];
        CFG_X_START:     x_start_r     <= cfg_data;
        CFG_Y_START:     y_start_r     <= cfg_data;
        CFG_X_STEP:      x_step_r      <= cfg_data;
        CFG_Y_STEP:      y_step_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Prototype memory.
  entry_t             wr_entry, rd_entry;
  logic [ENTRY_W-1:0] rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   rd_addr_r;

  assign wr_entry = '{metric_a: in_metric_a, metric_b: in_metric_b, metric_d: in_metric_d,
                      centre_x: in_centre_x, centre_y: in_centre_y, offset: in_offset,
                      cls: in_class_in};
  assign wr_en    = cmd.write && ({{(32 - ENTRY_IDX_W){1'b0}}, in_entry_index} < MAX_U);
  assign rd_entry = entry_t'(rd_data);

  npg_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (IDX_W'(in_entry_index)),
    .wdata (wr_entry),
    .re    (cmd.issue),
    .raddr (rd_addr_r),
    .rdata (rd_data)
  );

  // Grid coordinates of the classify beat, formed once at acceptance.
  logic [COORD_W-1:0]          col_m, row_m;
  logic signed [COORD_W+Q_W:0] x_prod, y_prod;
  logic signed [COORD_W+Q_W+1:0] x_sum, y_sum;
  logic signed [Q_W-1:0]       x_r, y_r, x_nxt, y_nxt;

  always_comb begin
    col_m  = in_column & GRID_MASK;
    row_m  = in_grid_row & GRID_MASK;
    x_prod = $signed({1'b0, col_m}) * x_step_r;
    y_prod = $signed({1'b0, row_m}) * y_step_r;
    x_sum  = (COORD_W+Q_W+2)'(x_prod) + (COORD_W+Q_W+2)'(x_start_r);
    y_sum  = (COORD_W+Q_W+2)'(y_prod) + (COORD_W+Q_W+2)'(y_start_r);
    x_nxt  = sat_q(64'(x_sum));
    y_nxt  = sat_q(64'(y_sum));
  end

  // Scan address and the last entry to search.
  logic [CNT_W-1:0] cnt_ext;
  logic [IDX_W-1:0] last_idx;

  always_comb begin
    cnt_ext = CNT_W'(proto_count_r);
    if (cnt_ext == '0) begin
      last_idx = '0;
    end else if (cnt_ext > MAX_CNT) begin
      last_idx = LAST_MAX;
    end else begin
      last_idx = IDX_W'(cnt_ext - CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_r       <= x_nxt;
      y_r       <= y_nxt;
      rd_addr_r <= '0;
    end else if (cmd.issue) begin
      rd_addr_r <= rd_addr_r + IDX_W'(1);
    end
  end

  // Stage valid bits.
  logic p0_v_r, a_v_r, b_v_r, c_v_r, d_v_r, e_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r <= 1'b0;
      a_v_r  <= 1'b0;
      b_v_r  <= 1'b0;
      c_v_r  <= 1'b0;
      d_v_r  <= 1'b0;
      e_v_r  <= 1'b0;
    end else begin
      p0_v_r <= cmd.issue;
      a_v_r  <= p0_v_r;
      b_v_r  <= a_v_r;
      c_v_r  <= b_v_r;
      d_v_r  <= c_v_r;
      e_v_r  <= d_v_r;
    end
  end

  assign st.issue_last = (rd_addr_r == last_idx);
  assign st.pipe_empty = !(p0_v_r || a_v_r || b_v_r || c_v_r || d_v_r || e_v_r);

  // Scoring pipeline payload.
  logic [IDX_W-1:0]          p0_idx_r, a_idx_r, b_idx_r, c_idx_r, d_idx_r, e_idx_r;
  logic [CLASS_W-1:0]        a_cls_r, b_cls_r, c_cls_r, d_cls_r, e_cls_r;
  logic signed [Q_W-1:0]     a_off_r, b_off_r, c_off_r, d_off_r;
  logic signed [Q_W-1:0]     a_ma_r, a_mb_r, a_md_r, dx_r, dy_r;
  logic signed [63:0]        pa_r, pb_r, pd_r, uu_r, vv_r;
  logic signed [Q_W-1:0]     u_r, v_r, u_nxt, v_nxt;
  logic signed [SCORE_W-1:0] score_r, score_nxt;
  logic signed [SCORE_W:0]   sum_uv;
  logic signed [SCORE_W+1:0] sum_s;

  always_comb begin
    // A product shifted right by 16 is already rounded toward minus infinity.
    sum_uv    = (SCORE_W+1)'(pa_r >>> 16) + (SCORE_W+1)'(pb_r >>> 16);
    u_nxt     = sat_q(64'(sum_uv));
    v_nxt     = sat_q(pd_r >>> 16);
    sum_s     = (SCORE_W+2)'(uu_r >>> 16) + (SCORE_W+2)'(vv_r >>> 16) + (SCORE_W+2)'(d_off_r);
    score_nxt = sat_score(64'(sum_s));
  end

  always_ff @(posedge clk) begin
    p0_idx_r <= rd_addr_r;
    // Offsets from the entry's centre.
    a_idx_r  <= p0_idx_r;
    a_cls_r  <= rd_entry.cls;
    a_off_r  <= rd_entry.offset;
    a_ma_r   <= rd_entry.metric_a;
    a_mb_r   <= rd_entry.metric_b;
    a_md_r   <= rd_entry.metric_d;
    dx_r     <= sat_q(64'(x_r) - 64'(rd_entry.centre_x));
    dy_r     <= sat_q(64'(y_r) - 64'(rd_entry.centre_y));
    // Metric products.
    b_idx_r  <= a_idx_r;
    b_cls_r  <= a_cls_r;
    b_off_r  <= a_off_r;
    pa_r     <= a_ma_r * dx_r;
    pb_r     <= a_mb_r * dy_r;
    pd_r     <= a_md_r * dy_r;
    // Saturated u and v.
    c_idx_r  <= b_idx_r;
    c_cls_r  <= b_cls_r;
    c_off_r  <= b_off_r;
    u_r      <= u_nxt;
    v_r      <= v_nxt;
    // Squares.
    d_idx_r  <= c_idx_r;
    d_cls_r  <= c_cls_r;
    d_off_r  <= c_off_r;
    uu_r     <= u_r * u_r;
    vv_r     <= v_r * v_r;
    // Final score.
    e_idx_r  <= d_idx_r;
    e_cls_r  <= d_cls_r;
    score_r  <= score_nxt;
  end

  // Best entry so far; a strict compare keeps the lower index on a tie.
  logic                      have_best_r;
  logic signed [SCORE_W-1:0] best_score_r;
  logic [IDX_W-1:0]          best_idx_r;
  logic [CLASS_W-1:0]        best_cls_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r <= 1'b0;
    end else if (cmd.start) begin
      have_best_r <= 1'b0;
    end else if (e_v_r) begin
      have_best_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (e_v_r && (!have_best_r || (score_r < best_score_r))) begin
      best_score_r <= score_r;
      best_idx_r   <= e_idx_r;
      best_cls_r   <= e_cls_r;
    end
  end

  // Result register.
  logic [CLASS_W-1:0]     out_class_r;
  logic [ENTRY_IDX_W-1:0] out_entry_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_class_r <= best_cls_r;
      out_entry_r <= ENTRY_IDX_W'(best_idx_r);
    end
  end

  assign out_class_out  = out_class_r;
  assign out_best_entry = out_entry_r;

endmodule

>>> design/nearest_prototype_grid_classifier_unit.sv
// Nearest-prototype grid classifier: a load beat (kind 0) writes one prototype entry. A
// classify beat (kind 1) places the grid cell at x_start + column*x_step, y_start +
// grid_row*y_step, scores the first proto_count entries with each entry's local 2x2 metric
// and bias, and returns the label and index of the lowest score, the lower index winning a
// tie. The entries searched number proto_count, held between 1 and MAX_ENTRIES; the
// prototype memory delivers one entry per cycle into a scoring pipeline, which is then
// drained before the result is loaded. The next beat is accepted as soon as the result sits
// in the output register. Entries must be loaded before they are searched; the table is not
// cleared by reset. Configuration must be written only while idle; the block itself does
// not enforce this.
module nearest_prototype_grid_classifier_unit #(
  parameter int MAX_ENTRIES = 64,
  parameter int GRID_BITS   = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_kind,
  input  logic [npg_pkg::ENTRY_IDX_W-1:0]      in_entry_index,
  input  logic signed [npg_pkg::Q_W-1:0]       in_metric_a,
  input  logic signed [npg_pkg::Q_W-1:0]       in_metric_b,
  input  logic signed [npg_pkg::Q_W-1:0]       in_metric_d,
  input  logic signed [npg_pkg::Q_W-1:0]       in_centre_x,
  input  logic signed [npg_pkg::Q_W-1:0]       in_centre_y,
  input  logic signed [npg_pkg::Q_W-1:0]       in_offset,
  input  logic [npg_pkg::CLASS_W-1:0]          in_class_in,
  input  logic [npg_pkg::COORD_W-1:0]          in_column,
  input  logic [npg_pkg::COORD_W-1:0]          in_grid_row,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [npg_pkg::CLASS_W-1:0]          out_class_out,
  output logic [npg_pkg::ENTRY_IDX_W-1:0]      out_best_entry,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [npg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [npg_pkg::Q_W-1:0]              cfg_data
);
  import npg_pkg::*;

  cmd_t    cmd;
  status_t st;

  // Registers are plain flops, so a configuration beat is always taken at once.
  assign cfg_ready = 1'b1;

  npg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .st        (st)
  );

  npg_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .GRID_BITS   (GRID_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_entry_index (in_entry_index),
    .in_metric_a    (in_metric_a),
    .in_metric_b    (in_metric_b),
    .in_metric_d    (in_metric_d),
    .in_centre_x    (in_centre_x),
    .in_centre_y    (in_centre_y),
    .in_offset      (in_offset),
    .in_class_in    (in_class_in),
    .in_column      (in_column),
    .in_grid_row    (in_grid_row),
    .out_class_out  (out_class_out),
    .out_best_entry (out_best_entry)
  );

endmodule

>>> tb/sv/nearest_prototype_grid_classifier_unit_test.sv
// Self-checking testbench for the nearest-prototype grid classifier with its own scoring model.
`timescale 1ns / 100ps

module nearest_prototype_grid_classifier_unit_test;
  import npg_pkg::*;

  localparam int ENTRIES = 64;
  localparam int unsigned ITEM_GOAL = 1950;
  localparam int unsigned QUIET_CYCLES = 90;
  localparam int unsigned CYCLE_LIMIT = 2500000;
  localparam int unsigned REPORT_LIMIT = 10;

  localparam logic signed [63:0] Q_HI = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] Q_LO = -64'sh0000_0000_8000_0000;
  localparam logic signed [63:0] SC_HI = 64'sh0000_7fff_ffff_ffff;
  localparam logic signed [63:0] SC_LO = -64'sh0000_8000_0000_0000;
  localparam logic signed [Q_W-1:0] Q_MAX32 = 32'sh7fff_ffff;
  localparam logic signed [Q_W-1:0] Q_MIN32 = 32'sh8000_0000;
  localparam logic [COORD_W-1:0] CELL_MAX = '1;

  typedef struct {
    logic                   kind;
    logic [ENTRY_IDX_W-1:0] slot;
    entry_t                 proto;
    logic [COORD_W-1:0]     col;
    logic [COORD_W-1:0]     row;
    bit                     wait_drain;
  } beat_t;

  typedef struct {
    logic [CLASS_W-1:0]     cls;
    logic [ENTRY_IDX_W-1:0] idx;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_kind = KIND_LOAD;
  logic [ENTRY_IDX_W-1:0] in_entry_index = '0;
  logic signed [Q_W-1:0]  in_metric_a = '0;
  logic signed [Q_W-1:0]  in_metric_b = '0;
  logic signed [Q_W-1:0]  in_metric_d = '0;
  logic signed [Q_W-1:0]  in_centre_x = '0;
  logic signed [Q_W-1:0]  in_centre_y = '0;
  logic signed [Q_W-1:0]  in_offset = '0;
  logic [CLASS_W-1:0]     in_class_in = '0;
  logic [COORD_W-1:0]     in_column = '0;
  logic [COORD_W-1:0]     in_grid_row = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [CLASS_W-1:0]     out_class_out;
  logic [ENTRY_IDX_W-1:0] out_best_entry;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_PROTO_COUNT;
  logic [Q_W-1:0]         cfg_data = '0;

  // Predictor state: the prototype table and a copy of the grid registers.
  entry_t                proto_table [ENTRIES];
  logic [PCOUNT_W-1:0]   searched_count = 7'd1;
  logic signed [Q_W-1:0] grid_x0 = '0;
  logic signed [Q_W-1:0] grid_y0 = '0;
  logic signed [Q_W-1:0] grid_dx = '0;
  logic signed [Q_W-1:0] grid_dy = '0;

  entry_t      gen_shadow [ENTRIES];
  beat_t       pending_beats [$];
  verdict_t    predicted_winners [$];
  beat_t       on_wire;
  verdict_t    want;
  bit          calm = 1'b0;
  int unsigned sender_gap = 0;
  int unsigned stall_left = 0;
  int unsigned mismatch_count = 0;
  int unsigned queued_items = 0;
  int unsigned cycle_count = 0;

  nearest_prototype_grid_classifier_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_entry_index (in_entry_index),
    .in_metric_a    (in_metric_a),
    .in_metric_b    (in_metric_b),
    .in_metric_d    (in_metric_d),
    .in_centre_x    (in_centre_x),
    .in_centre_y    (in_centre_y),
    .in_offset      (in_offset),
    .in_class_in    (in_class_in),
    .in_column      (in_column),
    .in_grid_row    (in_grid_row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_class_out  (out_class_out),
    .out_best_entry (out_best_entry),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic signed [63:0] wide(input logic signed [Q_W-1:0] v);
    return v;
  endfunction

  function automatic logic signed [63:0] clamp_q(input logic signed [63:0] v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  // Exact product, then an arithmetic shift, which rounds toward minus infinity.
  function automatic logic signed [63:0] fix_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p >>> 16;
  endfunction

  function automatic logic signed [63:0] entry_score(input entry_t p,
                                                      input logic signed [63:0] x,
                                                      input logic signed [63:0] y);
    logic signed [63:0] dx, dy, u, v, s;
    dx = clamp_q(x - wide(p.centre_x));
    dy = clamp_q(y - wide(p.centre_y));
    u = clamp_q(fix_mul(wide(p.metric_a), dx) + fix_mul(wide(p.metric_b), dy));
    v = clamp_q(fix_mul(wide(p.metric_d), dy));
    s = fix_mul(u, u) + fix_mul(v, v) + wide(p.offset);
    if (s > SC_HI) s = SC_HI;
    if (s < SC_LO) s = SC_LO;
    return s;
  endfunction

  function automatic verdict_t nearest_entry(input logic [COORD_W-1:0] col,
                                             input logic [COORD_W-1:0] row);
    logic signed [63:0] x, y, s, best_s;
    int unsigned n, best;
    verdict_t r;
    x = clamp_q(wide(grid_x0) + $signed({52'd0, col}) * wide(grid_dx));
    y = clamp_q(wide(grid_y0) + $signed({52'd0, row}) * wide(grid_dy));
    n = searched_count;
    if (n == 0) n = 1;
    if (n > ENTRIES) n = ENTRIES;
    best = 0;
    best_s = entry_score(proto_table[0], x, y);
    for (int unsigned e = 1; e < n; e++) begin
      s = entry_score(proto_table[e], x, y);
      // Strictly lower only, so the lower index keeps a tie.
      if (s < best_s) begin
        best_s = s;
        best = e;
      end
    end
    r.cls = proto_table[best].cls;
    r.idx = best[ENTRY_IDX_W-1:0];
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 120);
  endfunction

  // Mostly values near zero so that scores stay apart, with extremes and raw words mixed in.
  function automatic logic signed [Q_W-1:0] pick_q(input int unsigned span);
    int unsigned r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      case ($urandom_range(0, 4))
        0: return Q_MAX32;
        1: return Q_MIN32;
        2: return 32'sd0;
        3: return -32'sd1;
        default: return 32'sd1;
      endcase
    end
    if (r < 25) return $urandom();
    v = int'($urandom_range(0, 2 * span)) - int'(span);
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] pick_cell();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return CELL_MAX;
    if (r < 50) return COORD_W'($urandom_range(0, 15));
    return COORD_W'($urandom());
  endfunction

  function automatic entry_t random_proto();
    entry_t p;
    p.metric_a = pick_q(1 << 17);
    p.metric_b = pick_q(1 << 17);
    p.metric_d = pick_q(1 << 17);
    p.centre_x = pick_q(1 << 26);
    p.centre_y = pick_q(1 << 26);
    p.offset = pick_q(1 << 24);
    p.cls = CLASS_W'($urandom());
    return p;
  endfunction

  function automatic entry_t make_proto(input logic signed [Q_W-1:0] ma, mb, md, cx, cy, off,
                                        input logic [CLASS_W-1:0] cls);
    entry_t p;
    p.metric_a = ma;
    p.metric_b = mb;
    p.metric_d = md;
    p.centre_x = cx;
    p.centre_y = cy;
    p.offset = off;
    p.cls = cls;
    return p;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // An accepted beat either rewrites a table entry or yields one predicted winner.
  task automatic apply_beat(input beat_t b);
    if (b.kind == KIND_LOAD) begin
      proto_table[b.slot] = b.proto;
    end else begin
      predicted_winners = {predicted_winners, nearest_entry(b.col, b.row)};
    end
  endtask

  task automatic push_beat(input logic kind, input logic [ENTRY_IDX_W-1:0] slot,
                           input entry_t p, input logic [COORD_W-1:0] col,
                           input logic [COORD_W-1:0] row, input bit hold);
    beat_t b;
    b.kind = kind;
    b.slot = slot;
    b.proto = p;
    b.col = col;
    b.row = row;
    b.wait_drain = hold;
    if (kind == KIND_LOAD) gen_shadow[slot] = p;
    pending_beats = {pending_beats, b};
    queued_items++;
  endtask

  task automatic push_load(input logic [ENTRY_IDX_W-1:0] slot, input entry_t p);
    push_beat(KIND_LOAD, slot, p, COORD_W'($urandom()), COORD_W'($urandom()), 1'b0);
  endtask

  task automatic push_classify(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    push_beat(KIND_CLASSIFY, ENTRY_IDX_W'($urandom()), random_proto(), col, row, 1'b0);
  endtask

  task automatic settle();
    while (pending_beats.size() != 0 || in_valid || predicted_winners.size() != 0) begin
      @(posedge clk);
    end
    // A trailing load or classify may still be in flight inside the block.
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PROTO_COUNT: searched_count = data[PCOUNT_W-1:0];
      CFG_X_START:     grid_x0 = data;
      CFG_Y_START:     grid_y0 = data;
      CFG_X_STEP:      grid_dx = data;
      CFG_Y_STEP:      grid_dy = data;
      default: ;
    endcase
  endtask

  task automatic write_count(input int unsigned cnt);
    logic [Q_W-1:0] word;
    word = $urandom();
    if ($urandom_range(0, 1) != 0) word[Q_W-1:PCOUNT_W] = '0;
    word[PCOUNT_W-1:0] = PCOUNT_W'(cnt);
    write_reg(CFG_PROTO_COUNT, word);
  endtask

  task automatic write_unused_reg();
    write_reg(CFG_IDX_W'($urandom_range(int'(CFG_Y_STEP) + 1, (1 << CFG_IDX_W) - 1)),
              $urandom());
  endtask

  task automatic randomize_grid(input int unsigned phase_no);
    int unsigned r, cnt;
    r = $urandom_range(0, 99);
    if (phase_no == 0) cnt = (1 << PCOUNT_W) - 1;
    else if (r < 8) cnt = 0;
    else if (r < 16) cnt = $urandom_range(ENTRIES + 1, (1 << PCOUNT_W) - 1);
    else if (r < 22) cnt = ENTRIES;
    else if (r < 35) cnt = $urandom_range(1, ENTRIES);
    else cnt = $urandom_range(1, 8);
    write_count(cnt);
    write_reg(CFG_X_START, pick_q(1 << 26));
    write_reg(CFG_Y_START, pick_q(1 << 26));
    write_reg(CFG_X_STEP, pick_q(1 << 16));
    write_reg(CFG_Y_STEP, pick_q(1 << 16));
    if ($urandom_range(0, 3) == 0) write_unused_reg();
  endtask

  // Every slot is loaded by now, so any count may be searched.
  task automatic queue_random_phase(input int unsigned n, input bit force_pause);
    int unsigned i, r;
    logic [ENTRY_IDX_W-1:0] slot;
    entry_t p;
    bit hold;
    for (i = 0; i < n; i++) begin
      hold = ($urandom_range(0, 49) == 0) || (force_pause && i == n / 2);
      r = $urandom_range(0, 99);
      if (r < 35) begin
        slot = ENTRY_IDX_W'($urandom());
        p = random_proto();
        // A copy of another entry sets up a tie between two slots.
        if ($urandom_range(0, 5) == 0) begin
          p = gen_shadow[$urandom_range(0, ENTRIES - 1)];
          p.cls = CLASS_W'($urandom());
        end
        push_beat(KIND_LOAD, slot, p, COORD_W'($urandom()), COORD_W'($urandom()), hold);
      end else begin
        push_beat(KIND_CLASSIFY, ENTRY_IDX_W'($urandom()), random_proto(), pick_cell(),
                  pick_cell(), hold);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
      // The stalled beat stays on the wires unchanged.
    end else begin
      if (in_valid) apply_beat(on_wire);
      if (sender_gap != 0) begin
        sender_gap--;
        in_valid <= 1'b0;
      end else if (pending_beats.size() == 0 ||
                   (pending_beats[0].wait_drain && predicted_winners.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        on_wire = pending_beats.pop_front();
        in_kind <= on_wire.kind;
        in_entry_index <= on_wire.slot;
        in_metric_a <= on_wire.proto.metric_a;
        in_metric_b <= on_wire.proto.metric_b;
        in_metric_d <= on_wire.proto.metric_d;
        in_centre_x <= on_wire.proto.centre_x;
        in_centre_y <= on_wire.proto.centre_y;
        in_offset <= on_wire.proto.offset;
        in_class_in <= on_wire.proto.cls;
        in_column <= on_wire.col;
        in_grid_row <= on_wire.row;
        in_valid <= 1'b1;
        sender_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_winners.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected: class %0d entry %0d",
                                  out_class_out, out_best_entry));
      end else begin
        want = predicted_winners.pop_front();
        if (out_class_out !== want.cls || out_best_entry !== want.idx) begin
          report_mismatch($sformatf("class %0d entry %0d, expected class %0d entry %0d",
                                    out_class_out, out_best_entry, want.cls, want.idx));
        end
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase_no, n, s;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset grid: one entry searched, every cell at the origin.
    push_load(0, make_proto(Q_MAX32, Q_MAX32, Q_MAX32, Q_MIN32, Q_MIN32, Q_MAX32, 8'hff));
    push_classify(CELL_MAX, CELL_MAX);
    push_load(ENTRY_IDX_W'(ENTRIES - 1),
              make_proto(Q_MIN32, Q_MIN32, Q_MIN32, Q_MIN32, Q_MIN32, Q_MIN32, 8'ha5));
    push_load(0, make_proto(Q_MIN32, Q_MIN32, Q_MIN32, Q_MAX32, Q_MAX32, Q_MIN32, 8'h00));
    push_classify(0, 0);
    settle();

    // A count of zero still searches one entry; the grid corners saturate.
    write_count(0);
    write_reg(CFG_X_START, Q_MAX32);
    write_reg(CFG_Y_START, Q_MIN32);
    write_reg(CFG_X_STEP, Q_MAX32);
    write_reg(CFG_Y_STEP, Q_MIN32);
    push_classify(CELL_MAX, CELL_MAX);
    push_classify(1, 0);
    // Three equal zero-metric entries tie; entry 0 scores worst.
    push_load(1, make_proto(0, 0, 0, $urandom(), $urandom(), 0, 8'd11));
    push_load(2, make_proto(0, 0, 0, $urandom(), $urandom(), 0, 8'd22));
    push_load(3, make_proto(0, 0, 0, $urandom(), $urandom(), 0, 8'd33));
    push_load(0, make_proto(0, 0, 0, Q_MIN32, Q_MAX32, Q_MAX32, 8'h5a));
    settle();

    write_count(4);
    for (s = int'(CFG_Y_STEP) + 1; s < (1 << CFG_IDX_W); s++) begin
      write_reg(CFG_IDX_W'(s), $urandom());
    end
    push_classify(0, 0);
    push_classify(CELL_MAX, 0);
    push_load(1, make_proto(0, 0, 0, 0, 0, Q_MIN32, 8'd77));
    push_classify(7, 9);
    settle();

    // Fill the whole table before the random part.
    calm = 1'b1;
    for (s = 0; s < ENTRIES; s++) push_load(ENTRY_IDX_W'(s), random_proto());
    settle();

    phase_no = 0;
    while (queued_items < ITEM_GOAL) begin
      calm = ($urandom_range(0, 4) == 0);
      randomize_grid(phase_no);
      n = $urandom_range(40, 120);
      if (n > ITEM_GOAL - queued_items) n = ITEM_GOAL - queued_items;
      queue_random_phase(n, phase_no == 0);
      settle();
      phase_no++;
    end

    if (predicted_winners.size() != 0) begin
      $display("%0d expected results never arrived", predicted_winners.size());
    end
    if (mismatch_count == 0 && predicted_winners.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/npg_pkg.sv
design/npg_ram.sv
design/npg_ctrl.sv
design/npg_datapath.sv
design/nearest_prototype_grid_classifier_unit.sv
tb/sv/nearest_prototype_grid_classifier_unit_test.sv
